### rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// combinational implication checked on every rising clock edge
`define MBLP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define MBLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mblp_pkg.sv
package mblp_pkg;

  localparam int NUM_BUTTONS_DEF = 8;
  localparam int MAX_LANES       = 8;
  localparam logic [15:0] LONG_MS_RESET = 16'd500;

  typedef enum logic [1:0] {
    OP_POLL      = 2'd0,
    OP_CLR_SHORT = 2'd1,
    OP_CLR_LONG  = 2'd2,
    OP_SEED      = 2'd3
  } op_t;

  typedef struct packed {
    op_t         operation;
    logic [7:0]  button_levels;
    logic [31:0] now_ms;
    logic [2:0]  button_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pressed_flags;
    logic [7:0] held_flags;
    logic [7:0] long_flags;
  } out_item_t;

  // broadcast from the top level to every lane
  typedef struct packed {
    logic        accept;
    op_t         op;
    logic [31:0] now_ms;
    logic [15:0] long_ms;
  } lane_ctl_t;

  typedef struct packed {
    logic press_flag;
    logic held_flag;
    logic long_flag;
  } lane_stat_t;

endpackage

### rtl/mblp_lane.sv
module mblp_lane (
  input  logic               clk,
  input  logic               rst,
  input  mblp_pkg::lane_ctl_t ctl,
  input  logic               level,
  input  logic               clr_hit,
  output mblp_pkg::lane_stat_t cur,
  output mblp_pkg::lane_stat_t nxt
);

  logic        held, held_next;
  logic        press, press_next;
  logic        long_flag, long_flag_next;
  logic        fired, fired_next;
  logic [31:0] start_ms, start_ms_next;
  logic [31:0] elapsed;
  logic        reach;

  // wrapping elapsed time against the threshold
  assign elapsed = ctl.now_ms - start_ms;
  assign reach   = (elapsed >= {16'd0, ctl.long_ms});

  always_comb begin
    held_next      = held;
    press_next     = press;
    long_flag_next = long_flag;
    fired_next     = fired;
    start_ms_next  = start_ms;
    if (ctl.accept) begin
      case (ctl.op)
        mblp_pkg::OP_POLL: begin
          if (level && !held) begin
            press_next    = 1'b1;
            start_ms_next = ctl.now_ms;
            fired_next    = 1'b0;
          end else if (level && held && !fired) begin
            if (reach) begin
              long_flag_next = 1'b1;
              fired_next     = 1'b1;
            end
          end else if (!level && held) begin
            long_flag_next = 1'b0;
            fired_next     = 1'b0;
          end
          held_next = level;
        end
        mblp_pkg::OP_CLR_SHORT: begin
          if (clr_hit) press_next = 1'b0;
        end
        mblp_pkg::OP_CLR_LONG: begin
          if (clr_hit) long_flag_next = 1'b0;
        end
        mblp_pkg::OP_SEED: begin
          held_next     = level;
          start_ms_next = ctl.now_ms;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= 1'b0;
      press     <= 1'b0;
      long_flag <= 1'b0;
      fired     <= 1'b0;
    end else begin
      held      <= held_next;
      press     <= press_next;
      long_flag <= long_flag_next;
      fired     <= fired_next;
    end
  end

  always_ff @(posedge clk) begin
    start_ms <= start_ms_next;
  end

  assign cur = '{press_flag: press, held_flag: held, long_flag: long_flag};
  assign nxt = '{press_flag: press_next, held_flag: held_next, long_flag: long_flag_next};

endmodule

### rtl/mblp_out_buf.sv
module mblp_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  mblp_pkg::out_item_t push_data,
  output logic                has_room,
  output logic                out_valid,
  input  logic                out_ready,
  output mblp_pkg::out_item_t out_data
);

  mblp_pkg::out_item_t slot [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign has_room  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_data;
  end

endmodule

### rtl/multi_button_long_press_detector.sv
// a result is registered into the output buffer when its item is accepted
// throughput: one item per cycle while the output buffer has room, every button lane updates in the accept cycle
// a two-entry output buffer keeps input accepting while one result waits
// reset (rst, synchronous, active high): flags, levels and buffer clear,
// the hold threshold returns to 500
`include "assert_macros.svh"

module multi_button_long_press_detector #(
  parameter int NUM_BUTTONS = mblp_pkg::NUM_BUTTONS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mblp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mblp_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata
);

  // only buttons below both the parameter and the field width are tracked
  localparam int LANES = (NUM_BUTTONS < mblp_pkg::MAX_LANES) ? NUM_BUTTONS
                                                            : mblp_pkg::MAX_LANES;
  localparam logic [7:0] LANE_MASK = 8'((1 << LANES) - 1);

  logic                 accept;
  logic [15:0]          long_ms;
  mblp_pkg::lane_ctl_t  ctl;
  logic [7:0]           press_vec, held_vec, long_vec;
  logic [7:0]           press_nxt, held_nxt, long_nxt;
  mblp_pkg::out_item_t  result;
  logic                 has_room;
  logic [7:0]           lv_masked;

  assign in_ready  = has_room;
  assign accept    = in_valid && in_ready;
  assign lv_masked = in_data.button_levels & LANE_MASK;

  // threshold register, the user must write it only while idle; the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      long_ms <= mblp_pkg::LONG_MS_RESET;
    end else if (cfg_we) begin
      long_ms <= cfg_wdata;
    end
  end

  // one control bundle broadcast to every lane
  assign ctl = '{accept: accept, op: in_data.operation, now_ms: in_data.now_ms,
                 long_ms: long_ms};

  // one lane per tracked button, missing buttons read as zero
  for (genvar i = 0; i < mblp_pkg::MAX_LANES; i++) begin : g_lane
    if (i < LANES) begin : g_on
      mblp_pkg::lane_stat_t cur, nxt;
      mblp_lane u_lane (
        .clk     (clk),
        .rst     (rst),
        .ctl     (ctl),
        .level   (in_data.button_levels[i]),
        .clr_hit (in_data.button_index == 3'(i)),
        .cur     (cur),
        .nxt     (nxt)
      );
      assign press_vec[i] = cur.press_flag;
      assign held_vec[i]  = cur.held_flag;
      assign long_vec[i]  = cur.long_flag;
      assign press_nxt[i] = nxt.press_flag;
      assign held_nxt[i]  = nxt.held_flag;
      assign long_nxt[i]  = nxt.long_flag;
    end else begin : g_off
      assign press_vec[i] = 1'b0;
      assign held_vec[i]  = 1'b0;
      assign long_vec[i]  = 1'b0;
      assign press_nxt[i] = 1'b0;
      assign held_nxt[i]  = 1'b0;
      assign long_nxt[i]  = 1'b0;
    end
  end

  // merge the lane flags into one result item
  assign result = '{pressed_flags: press_nxt, held_flags: held_nxt, long_flags: long_nxt};

  mblp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .has_room  (has_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a stalled input means the buffer holds results to drain
  `MBLP_ASSERT_NOW(a_stall_has_data, !in_ready, out_valid, "input stalled with empty buffer")

  // poll and seed load the held levels of existing buttons
  `MBLP_ASSERT_NEXT(a_held_load, accept && (in_data.operation == mblp_pkg::OP_POLL || in_data.operation == mblp_pkg::OP_SEED), held_vec == $past(lv_masked), "held levels not loaded")

  // a rising edge on a poll latches the short press
  `MBLP_ASSERT_NEXT(a_press_latch, accept && in_data.operation == mblp_pkg::OP_POLL && (lv_masked & ~held_vec) != 8'd0, (press_vec & $past(lv_masked & ~held_vec)) == $past(lv_masked & ~held_vec), "short press not latched")

  // a long clear drops the named button's long flag
  `MBLP_ASSERT_NEXT(a_long_clear, accept && in_data.operation == mblp_pkg::OP_CLR_LONG, !long_vec[$past(in_data.button_index)], "long press not cleared")

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int N_BTN      = mblp_pkg::NUM_BUTTONS_DEF;
  localparam int LANES_USED = (N_BTN < 8) ? N_BTN : 8;
  localparam logic [7:0] LANE_MASK = (LANES_USED >= 8) ? 8'hFF : 8'((1 << LANES_USED) - 1);
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_AT_ITEM   = 300;
  localparam int HOLD_CYCLES    = 150;
  localparam int MAX_PRINTS     = 30;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  mblp_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  mblp_pkg::out_item_t out_data;
  logic                cfg_we = 1'b0;
  logic [15:0]         cfg_wdata = '0;

  multi_button_long_press_detector #(.NUM_BUTTONS(N_BTN)) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predicted button state, same reset values as the block, whose start times have no reset
  logic [15:0] mdl_long_ms = mblp_pkg::LONG_MS_RESET;
  logic [7:0]  mdl_held  = '0;
  logic [7:0]  mdl_press = '0;
  logic [7:0]  mdl_long  = '0;
  logic [7:0]  mdl_fired = '0;
  logic [31:0] mdl_start [8] = '{default: '0};

  mblp_pkg::in_item_t  pending_items [$];   // items waiting to be offered
  mblp_pkg::out_item_t expected_flags [$];  // predicted results, oldest first

  int mismatch_count = 0;
  int items_taken    = 0;
  int burst_left     = 0;
  int gap_left       = 0;
  int idle_cycles    = 0;

  // one item through the button model, returns the flags it leaves behind
  function automatic mblp_pkg::out_item_t press_model_step(mblp_pkg::in_item_t it);
    mblp_pkg::out_item_t r;
    logic [7:0]          lv;
    logic [31:0]         held_for;
    lv = it.button_levels & LANE_MASK;
    case (it.operation)
      mblp_pkg::OP_POLL: begin
        for (int b = 0; b < LANES_USED; b++) begin
          if (lv[b] && !mdl_held[b]) begin
            // rising edge: short press latches, hold timer restarts
            mdl_press[b] = 1'b1;
            mdl_start[b] = it.now_ms;
            mdl_fired[b] = 1'b0;
          end else if (lv[b] && mdl_held[b] && !mdl_fired[b]) begin
            // still held, long press fires once per hold, elapsed time wraps
            held_for = it.now_ms - mdl_start[b];
            if (held_for >= {16'h0, mdl_long_ms}) begin
              mdl_long[b]  = 1'b1;
              mdl_fired[b] = 1'b1;
            end
          end else if (!lv[b] && mdl_held[b]) begin
            mdl_long[b]  = 1'b0;
            mdl_fired[b] = 1'b0;
          end
        end
        mdl_held = lv;
      end
      mblp_pkg::OP_CLR_SHORT: begin
        if (it.button_index < LANES_USED) mdl_press[it.button_index] = 1'b0;
      end
      mblp_pkg::OP_CLR_LONG: begin
        if (it.button_index < LANES_USED) mdl_long[it.button_index] = 1'b0;
      end
      default: begin
        // seed: levels copied with no edge, every timer restarts
        mdl_held = lv;
        for (int b = 0; b < LANES_USED; b++) mdl_start[b] = it.now_ms;
      end
    endcase
    r.pressed_flags = mdl_press;
    r.held_flags    = mdl_held;
    r.long_flags    = mdl_long;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    if (mismatch_count < MAX_PRINTS)
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // sender: bursts of items with random gaps, payload held until taken
  always @(posedge clk) begin : drive_proc
    logic taken;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      taken = in_valid && in_ready;
      if (taken) begin
        expected_flags.push_back(press_model_step(in_data));
        items_taken <= items_taken + 1;
      end
      if (in_valid && !taken) begin
        // item still waiting, keep it on the bus
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern changes mode now and then, plus one long hold-off
  int   rx_mode = 0;
  int   rx_count = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;

  always @(posedge clk) begin : recv_proc
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      rx_count <= rx_count + 1;
      if ($urandom_range(0, 99) == 0) rx_mode <= $urandom_range(0, 3);
      if (!hold_done && items_taken >= HOLD_AT_ITEM) begin
        // block output for a long stretch so the buffer fills and input stalls
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= rx_count[2];
        endcase
      end
    end
  end

  // checker: each result against the oldest prediction
  always @(posedge clk) begin : check_proc
    mblp_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_flags.size() == 0) begin
        report_mismatch("result with no item pending", out_data.pressed_flags, 8'h00);
      end else begin
        want = expected_flags.pop_front();
        if (out_data.pressed_flags !== want.pressed_flags)
          report_mismatch("pressed_flags", out_data.pressed_flags, want.pressed_flags);
        if (out_data.held_flags !== want.held_flags)
          report_mismatch("held_flags", out_data.held_flags, want.held_flags);
        if (out_data.long_flags !== want.long_flags)
          report_mismatch("long_flags", out_data.long_flags, want.long_flags);
      end
    end
  end

  // watchdog: too long with no item moving on either side
  always @(posedge clk) begin : watchdog_proc
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", idle_cycles);
        $display("multi_button_long_press_detector test failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic queue_item(mblp_pkg::op_t op, logic [7:0] levels, logic [31:0] now,
                            logic [2:0] idx);
    mblp_pkg::in_item_t it;
    it.operation     = op;
    it.button_levels = levels;
    it.now_ms        = now;
    it.button_index  = idx;
    pending_items.push_back(it);
  endtask

  // everything sent and every result back, then a margin before returning
  // sampled at the falling edge so the sender's updates have settled
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_flags.size() != 0)
      @(negedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_threshold(logic [15:0] value);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    mdl_long_ms = value;
  endtask

  // press/release sequences: bits flip now and then, time mostly advances
  // in steps on the scale of the threshold, with some noise and jumps
  task automatic queue_random_phase(int count, logic [31:0] t_start);
    logic [7:0]    lv;
    logic [7:0]    levels;
    logic [31:0]   t;
    int            roll;
    int            step_max;
    mblp_pkg::op_t op;
    lv = 8'($urandom);
    t = t_start;
    step_max = mdl_long_ms / 3 + 2;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) t = $urandom;
      else if (roll < 15) t += $urandom_range(step_max, 3 * step_max);
      else t += $urandom_range(0, step_max);
      for (int b = 0; b < 8; b++)
        if ($urandom_range(0, 5) == 0) lv[b] = ~lv[b];
      levels = ($urandom_range(0, 9) == 0) ? 8'($urandom) : lv;
      roll = $urandom_range(0, 99);
      if (roll < 70) op = mblp_pkg::OP_POLL;
      else if (roll < 80) op = mblp_pkg::OP_CLR_SHORT;
      else if (roll < 90) op = mblp_pkg::OP_CLR_LONG;
      else op = mblp_pkg::OP_SEED;
      if (op == mblp_pkg::OP_POLL || op == mblp_pkg::OP_SEED) lv = levels;
      queue_item(op, levels, t, 3'($urandom_range(0, 7)));
    end
  endtask

  initial begin : stim_proc
    logic [31:0] t0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // default threshold of 500
    queue_item(mblp_pkg::OP_POLL, 8'h00, 32'd0, 3'd0);
    queue_item(mblp_pkg::OP_POLL, 8'hFF, 32'd100, 3'd7);       // every button rises
    queue_item(mblp_pkg::OP_POLL, 8'hFF, 32'd599, 3'd0);       // one short of long press
    queue_item(mblp_pkg::OP_POLL, 8'hFF, 32'd600, 3'd0);       // long press at threshold
    queue_item(mblp_pkg::OP_POLL, 8'hFF, 32'd5000, 3'd0);      // already fired, no change
    queue_item(mblp_pkg::OP_CLR_SHORT, 8'h00, 32'd0, 3'd0);
    queue_item(mblp_pkg::OP_CLR_LONG, 8'h00, 32'd0, 3'd7);
    queue_item(mblp_pkg::OP_POLL, 8'h0F, 32'd700, 3'd0);       // upper buttons released
    queue_item(mblp_pkg::OP_SEED, 8'hF0, 32'hFFFF_FFF0, 3'd0); // seed near the wrap point
    queue_item(mblp_pkg::OP_POLL, 8'hF0, 32'h0000_01E3, 3'd0); // elapsed 499 across wrap
    queue_item(mblp_pkg::OP_POLL, 8'hF0, 32'h0000_01E4, 3'd0); // elapsed 500 across wrap
    queue_item(mblp_pkg::OP_SEED, 8'h00, 32'hFFFF_FFFF, 3'd0); // levels drop, no edge
    queue_item(mblp_pkg::OP_POLL, 8'h01, 32'd10, 3'd0);        // rise keeps latched long flag
    queue_item(mblp_pkg::OP_CLR_SHORT, 8'hFF, 32'hFFFF_FFFF, 3'd3);
    queue_item(mblp_pkg::OP_CLR_LONG, 8'hAA, 32'h5555_5555, 3'd1);
    queue_item(mblp_pkg::OP_POLL, 8'hAA, 32'hAAAA_AAAA, 3'd5);
    queue_item(mblp_pkg::OP_POLL, 8'h55, 32'h5555_5555, 3'd2);
    queue_item(mblp_pkg::OP_CLR_SHORT, 8'h00, 32'd0, 3'd4);
    queue_item(mblp_pkg::OP_CLR_LONG, 8'h00, 32'd0, 3'd6);
    queue_item(mblp_pkg::OP_POLL, 8'h00, 32'h8000_0000, 3'd0);

    // zero threshold: long press on the first poll still held after the rise
    write_threshold(16'd0);
    queue_item(mblp_pkg::OP_POLL, 8'h80, 32'd10, 3'd0);
    queue_item(mblp_pkg::OP_POLL, 8'h80, 32'd10, 3'd0);
    queue_random_phase(150, 32'hFFFF_FF00);

    // largest threshold
    write_threshold(16'hFFFF);
    t0 = $urandom;
    queue_item(mblp_pkg::OP_POLL, 8'h00, t0, 3'd0);
    queue_item(mblp_pkg::OP_POLL, 8'h01, t0, 3'd0);
    queue_item(mblp_pkg::OP_POLL, 8'h01, t0 + 32'd65534, 3'd0);
    queue_item(mblp_pkg::OP_POLL, 8'h01, t0 + 32'd65535, 3'd0);
    queue_random_phase(150, $urandom);

    write_threshold(16'd7);
    queue_random_phase(150, $urandom);

    write_threshold(16'd40);
    queue_random_phase(150, $urandom);

    write_threshold(16'($urandom_range(0, 65535)));
    queue_random_phase(150, $urandom);

    wait_idle();
    if (mismatch_count == 0 && expected_flags.size() == 0) begin
      $display("multi_button_long_press_detector test passed");
    end else begin
      $display("multi_button_long_press_detector test failed");
    end
    $finish;
  end

endmodule
